### src/lpnsc_pkg.sv
package lpnsc_pkg;

  localparam int unsigned DATA_W       = 8;
  localparam int unsigned FLEN_IN_W    = 24;
  localparam int unsigned PREFIX_W     = 3;
  localparam int unsigned LEN_W        = 32;

  localparam logic [PREFIX_W-1:0] PREFIX_MIN   = 3'd1;
  localparam logic [PREFIX_W-1:0] PREFIX_MAX   = 3'd4;
  localparam logic [PREFIX_W-1:0] PREFIX_RESET = 3'd4;

  // start code is 00 00 00 01
  localparam logic [DATA_W-1:0] SC_ZERO_BYTE = 8'h00;
  localparam logic [DATA_W-1:0] SC_LAST_BYTE = 8'h01;
  localparam logic [1:0]        SC_LAST_IDX  = 2'd3;

  // what the parser hands to the result stage for one request
  typedef struct packed {
    logic              valid;
    logic              start;
    logic [DATA_W-1:0] data;
  } emit_t;

endpackage

### src/lpnsc_if.sv
interface lpnsc_in_if;
  import lpnsc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [DATA_W-1:0]    data_byte;
  logic [FLEN_IN_W-1:0] frame_length;
  logic                 frame_last;

  modport source (output valid, data_byte, frame_length, frame_last, input ready);
  modport sink   (input valid, data_byte, frame_length, frame_last, output ready);
endinterface

interface lpnsc_out_if;
  import lpnsc_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] out_byte;
  logic              run_last;

  modport source (output valid, out_byte, run_last, input ready);
  modport sink   (input valid, out_byte, run_last, output ready);
endinterface

interface lpnsc_cfg_if;
  import lpnsc_pkg::*;
  logic                valid;
  logic                ready;
  logic [PREFIX_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### src/length_prefixed_nal_to_start_code_core.sv
// Length-prefixed NAL to start-code converter.
// in_ch: one frame byte per request, with the frame length and a last-of-frame
//   flag. cfg_ch: prefix length in bytes (1..4), always ready; write it only
//   while no request is in flight.
// out_ch: output stream bytes. A completed length prefix yields the four bytes
//   00 00 00 01 (run_last on the 01); each payload byte yields one result with
//   run_last set. Header bytes, and everything after a zero or oversized
//   length, yield nothing.
// An accepted request passes the input register, then its result the result register.
// Throughput: one input request per cycle while out_ch is ready. The result
//   register is the only shared resource: a start-code run holds it until its
//   01 byte is taken, so input is held off after each completed prefix.
// An input register and the result register part the two channels, so a new
//   request is taken while a result still waits on a stalled receiver; with
//   out_ch stalled, input fills after one request and ready drops.
// Reset (rst_n low, synchronous): both registers empty, parser back to the
//   header phase at frame offset zero, prefix length back to 4.
module length_prefixed_nal_to_start_code_core
  import lpnsc_pkg::*;
#(
  parameter int unsigned FRAME_LENGTH_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  lpnsc_in_if.sink    in_ch,
  lpnsc_cfg_if.sink   cfg_ch,
  lpnsc_out_if.source out_ch
);

  logic                 in_valid_r;
  logic [DATA_W-1:0]    in_data_r;
  logic [FLEN_IN_W-1:0] in_flen_r;
  logic                 in_last_r;
  logic [PREFIX_W-1:0]  prefix_r;

  logic              run_valid_r;
  logic              run_start_r;
  logic [1:0]        run_idx_r;
  logic [DATA_W-1:0] run_byte_r;

  logic  run_end;
  logic  run_free;
  logic  take;
  emit_t emit;

  assign run_end  = !run_start_r || (run_idx_r == SC_LAST_IDX);
  assign run_free = !run_valid_r || (out_ch.ready && run_end);
  assign take     = in_valid_r && run_free;

  assign in_ch.ready  = !in_valid_r || take;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= PREFIX_RESET;
    end else if (cfg_ch.valid) begin
      prefix_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      in_data_r <= in_ch.data_byte;
      in_flen_r <= in_ch.frame_length;
      in_last_r <= in_ch.frame_last;
    end
  end

  lpnsc_parse #(
    .FRAME_LENGTH_BITS(FRAME_LENGTH_BITS)
  ) u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (take),
    .data        (in_data_r),
    .flen        (in_flen_r),
    .last        (in_last_r),
    .prefix_bytes(prefix_r),
    .emit        (emit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_valid_r <= 1'b0;
      run_idx_r   <= '0;
    end else if (take) begin
      run_valid_r <= emit.valid;
      run_idx_r   <= '0;
    end else if (run_valid_r && out_ch.ready) begin
      if (run_end) begin
        run_valid_r <= 1'b0;
      end else begin
        run_idx_r <= run_idx_r + 2'd1;
      end
    end
    if (take) begin
      run_start_r <= emit.start;
      run_byte_r  <= emit.data;
    end
  end

  assign out_ch.valid    = run_valid_r;
  assign out_ch.run_last = run_end;
  assign out_ch.out_byte = !run_start_r ? run_byte_r
                         : (run_idx_r == SC_LAST_IDX) ? SC_LAST_BYTE : SC_ZERO_BYTE;

endmodule

### src/lpnsc_parse.sv
module lpnsc_parse
  import lpnsc_pkg::*;
#(
  parameter int unsigned FRAME_LENGTH_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [DATA_W-1:0]    data,
  input  logic [FLEN_IN_W-1:0] flen,
  input  logic                 last,
  input  logic [PREFIX_W-1:0]  prefix_bytes,
  output emit_t                emit
);

  localparam int unsigned PW = FRAME_LENGTH_BITS;
  localparam int unsigned CW = LEN_W + 2;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_STOPPED = 2'd2
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [PW-1:0]       pos_r, pos_nxt;
  logic [PREFIX_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0]    acc_r, acc_nxt;
  logic [LEN_W-1:0]    rem_r, rem_nxt;

  logic [PREFIX_W-1:0] plen;
  logic [LEN_W-1:0]    flen32;
  logic [PW-1:0]       flen_m;
  logic [CW-1:0]       pos_w, flen_w;
  logic [LEN_W-1:0]    acc_new;
  logic [PREFIX_W-1:0] cnt_new;

  // out-of-range register values clamp to 1..4
  always_comb begin
    if (prefix_bytes == '0) begin
      plen = PREFIX_MIN;
    end else if (prefix_bytes > PREFIX_MAX) begin
      plen = PREFIX_MAX;
    end else begin
      plen = prefix_bytes;
    end
  end

  assign flen32  = LEN_W'(flen);
  assign flen_m  = flen32[PW-1:0];
  assign pos_w   = CW'(pos_r);
  assign flen_w  = CW'(flen_m);
  assign acc_new = {acc_r[LEN_W-DATA_W-1:0], data};
  assign cnt_new = cnt_r + PREFIX_W'(1);

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    rem_nxt    = rem_r;
    emit       = '0;

    case (phase_r)
      PH_HEADER: begin
        if (cnt_r == '0 && (pos_w + CW'(plen)) > flen_w) begin
          phase_nxt = PH_STOPPED;
        end else if (cnt_new >= plen) begin
          cnt_nxt = '0;
          acc_nxt = '0;
          if (acc_new == '0 || (pos_w + CW'(1) + CW'(acc_new)) > flen_w) begin
            phase_nxt = PH_STOPPED;
          end else begin
            emit.valid = 1'b1;
            emit.start = 1'b1;
            rem_nxt    = acc_new;
            phase_nxt  = PH_PAYLOAD;
          end
        end else begin
          cnt_nxt = cnt_new;
          acc_nxt = acc_new;
        end
      end
      PH_PAYLOAD: begin
        emit.valid = 1'b1;
        emit.data  = data;
        rem_nxt    = rem_r - LEN_W'(1);
        if (rem_nxt == '0) begin
          phase_nxt = PH_HEADER;
        end
      end
      default: begin
      end
    endcase

    if (pos_r != '1) begin
      pos_nxt = pos_r + PW'(1);
    end

    if (last) begin
      phase_nxt = PH_HEADER;
      pos_nxt   = '0;
      cnt_nxt   = '0;
      acc_nxt   = '0;
      rem_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
      cnt_r   <= '0;
      acc_r   <= '0;
      rem_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule

### src/lpnsc_chk.sv
module lpnsc_chk
  import lpnsc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_byte,
  input logic              out_run_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(out_run_last)))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // only start-code bytes are not last of their run, and those are zero
  a_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_run_last) |-> (out_byte == SC_ZERO_BYTE))
    else $error("nonzero byte inside start-code run");

  // a start-code run is never broken up
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_run_last) |=> out_valid)
    else $error("start-code run interrupted");

endmodule

bind length_prefixed_nal_to_start_code_core lpnsc_chk u_lpnsc_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .out_run_last(out_ch.run_last)
);
